### rtl/core/psf_pkg.sv
package psf_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_FILL  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam int RESULT_LIMIT = 8;

endpackage

### rtl/core/psf_if.sv
interface psf_in_if #(parameter int COORD_BITS = 10);
    logic                  valid;
    logic                  ready;
    logic [1:0]            operation;
    logic [COORD_BITS-1:0] coord_x;
    logic [COORD_BITS-1:0] coord_y;

    modport source (output valid, output operation, output coord_x, output coord_y,
                    input ready);
    modport sink (input valid, input operation, input coord_x, input coord_y,
                  output ready);
endinterface

interface psf_out_if #(parameter int COORD_BITS = 10);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] span_y;
    logic [COORD_BITS-1:0] span_x_first;
    logic [COORD_BITS-1:0] span_x_last;
    logic                  span_valid;
    logic                  overflow;
    logic                  last;

    modport source (output valid, output span_y, output span_x_first,
                    output span_x_last, output span_valid, output overflow,
                    output last, input ready);
    modport sink (input valid, input span_y, input span_x_first, input span_x_last,
                  input span_valid, input overflow, input last, output ready);
endinterface

### rtl/core/psf_divider.sv
// Restoring divider: unsigned numerator / denominator, one quotient bit a cycle
module psf_divider #(
    parameter int NUM_BITS = 20,
    parameter int DEN_BITS = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] numer,
    input  logic [DEN_BITS-1:0] denom,
    output logic                done,
    output logic [NUM_BITS-1:0] quot,
    output logic                rem_nz
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] quot_reg, quot_next;
    logic [DEN_BITS:0]   rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DEN_BITS+1:0] trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            quot_next = numer;
            rem_next  = '0;
            den_next  = denom;
            cnt_next  = CNT_BITS'(NUM_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in next numerator bit, subtract when it fits
            trial = {rem_reg, quot_reg[NUM_BITS-1]} - {2'b00, den_reg};
            if (!trial[DEN_BITS+1])
            begin
                rem_next = trial[DEN_BITS:0];
                quot_next = {quot_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DEN_BITS-1:0], quot_reg[NUM_BITS-1]};
                quot_next = {quot_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign done   = done_reg;
    assign quot   = quot_reg;
    assign rem_nz = (rem_reg != '0);
endmodule

### rtl/core/polygon_scanline_span_fill_top.sv
// Clear, add-vertex and unused-code words are handled in the idle state. A fill walks
// the edges with a serial divide per crossing, sorts the crossings by insertion, then
// reads and emits each span (an empty line gives one span with span_valid low), and
// waits on any output stall; one word is worked on at a time, and the next word
// waits until the last span of a fill has been taken. Asynchronous active-low reset
// clears the vertex count, overflow flag and control; memories are not cleared.
module polygon_scanline_span_fill_top #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_BITS   = 10
) (
    input  logic clk,
    input  logic rst_n,
    psf_in_if.sink    in_ch,
    psf_out_if.source out_ch
);
    localparam int IDX_BITS = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_BITS = $clog2(MAX_VERTICES + 1);
    localparam int NUM_BITS = 2 * COORD_BITS;
    localparam int PAIR_BITS = $clog2(psf_pkg::RESULT_LIMIT + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_EDGE_RD, S_EDGE_RD2, S_EDGE_EVAL, S_DIV_WAIT,
        S_SORT_RD, S_SORT_LD, S_SORT_CMP, S_SORT_PUT, S_EMIT_RD, S_EMIT_RD2, S_OUT
    } state_t;

    // vertex and crossing memories
    logic [2*COORD_BITS-1:0] vtx_mem [MAX_VERTICES];
    logic [COORD_BITS-1:0]   crs_mem [MAX_VERTICES];

    state_t                state_reg;
    logic [CNT_BITS-1:0]   vcount_reg;
    logic                  ovf_reg;
    logic [COORD_BITS-1:0] y_reg;
    logic [CNT_BITS-1:0]   edge_reg;      // current edge index i
    logic [CNT_BITS-1:0]   ccount_reg;    // crossings found
    logic [2*COORD_BITS-1:0] va_reg;      // first endpoint
    logic [2*COORD_BITS-1:0] vrd_reg;     // vertex read data
    logic [COORD_BITS-1:0] crd_reg;       // crossing read data
    logic [COORD_BITS-1:0] xlo_reg;
    logic                  neg_reg;
    logic [CNT_BITS-1:0]   si_reg;        // sort outer index
    logic [CNT_BITS-1:0]   sp_reg;        // sort insert position
    logic [COORD_BITS-1:0] sv_reg;        // value being inserted
    logic [PAIR_BITS-1:0]  pairs_reg;
    logic [PAIR_BITS-1:0]  k_reg;
    logic [COORD_BITS-1:0] first_reg;

    // output register
    logic                  ovalid_reg;
    logic [COORD_BITS-1:0] oy_reg, oxf_reg, oxl_reg;
    logic                  osv_reg, oovf_reg, olast_reg;

    // memory port controls
    logic                  vrd_en;
    logic [IDX_BITS-1:0]   vrd_addr;
    logic                  vwr_en;
    logic [IDX_BITS-1:0]   vwr_addr;
    logic                  crd_en;
    logic [IDX_BITS-1:0]   crd_addr;
    logic                  cwr_en;
    logic [IDX_BITS-1:0]   cwr_addr;
    logic [COORD_BITS-1:0] cwr_data;

    // divider
    logic                  div_start;
    logic [NUM_BITS-1:0]   div_numer;
    logic [COORD_BITS-1:0] div_denom;
    logic                  div_done;
    logic [NUM_BITS-1:0]   div_quot;
    logic                  div_rem_nz;

    psf_divider #(.NUM_BITS(NUM_BITS), .DEN_BITS(COORD_BITS)) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .numer  (div_numer),
        .denom  (div_denom),
        .done   (div_done),
        .quot   (div_quot),
        .rem_nz (div_rem_nz)
    );

    // edge geometry from the two endpoints
    logic [COORD_BITS-1:0] xa, ya, xb, yb, xlo, ylo, xhi, yhi;
    logic                  hit;
    logic [COORD_BITS-1:0] dx_abs;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS-1:0] dyc;
    logic [CNT_BITS-1:0]   next_edge;
    logic [IDX_BITS-1:0]   si_dbl;
    logic [COORD_BITS:0]   xc_sum;
    logic [COORD_BITS-1:0] q_adj;

    always_comb
    begin
        xa = va_reg[2*COORD_BITS-1:COORD_BITS];
        ya = va_reg[COORD_BITS-1:0];
        xb = vrd_reg[2*COORD_BITS-1:COORD_BITS];
        yb = vrd_reg[COORD_BITS-1:0];
        if (ya < yb)
        begin
            xlo = xa; ylo = ya; xhi = xb; yhi = yb;
        end
        else
        begin
            xlo = xb; ylo = yb; xhi = xa; yhi = ya;
        end
        hit    = (ya != yb) && (y_reg >= ylo) && (y_reg < yhi);
        dx_abs = (xhi >= xlo) ? (xhi - xlo) : (xlo - xhi);
        dy     = yhi - ylo;
        dyc    = y_reg - ylo;
        next_edge = edge_reg + 1'b1;
        si_dbl = IDX_BITS'({k_reg, 1'b0});
        // floor for negative slope: -(q + (rem != 0))
        q_adj  = div_quot[COORD_BITS-1:0] + {{(COORD_BITS-1){1'b0}}, div_rem_nz};
        xc_sum = neg_reg ? ({1'b0, xlo_reg} - {1'b0, q_adj})
                         : ({1'b0, xlo_reg} + {1'b0, div_quot[COORD_BITS-1:0]});
    end

    assign in_ch.ready = (state_reg == S_IDLE) && !ovalid_reg;
    wire in_acc = in_ch.valid && in_ch.ready;
    wire out_acc = out_ch.valid && out_ch.ready;

    // control
    always_comb
    begin
        vrd_en = 1'b0; vrd_addr = '0;
        vwr_en = 1'b0; vwr_addr = vcount_reg[IDX_BITS-1:0];
        crd_en = 1'b0; crd_addr = '0;
        cwr_en = 1'b0; cwr_addr = '0; cwr_data = '0;
        div_start = 1'b0;
        div_numer = NUM_BITS'(dyc) * NUM_BITS'(dx_abs);
        div_denom = dy;
        if (in_acc && (psf_pkg::op_t'(in_ch.operation) == psf_pkg::OP_ADD)
            && (vcount_reg < CNT_BITS'(MAX_VERTICES)))
            vwr_en = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc) begin vrd_en = 1'b1; vrd_addr = '0; end
            end
            S_EDGE_RD:
            begin
                vrd_en = 1'b1;
                vrd_addr = (next_edge == vcount_reg) ? '0 : next_edge[IDX_BITS-1:0];
            end
            S_EDGE_EVAL:
            begin
                if (hit) div_start = 1'b1;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    cwr_en = 1'b1;
                    cwr_addr = ccount_reg[IDX_BITS-1:0];
                    cwr_data = xc_sum[COORD_BITS-1:0];
                end
            end
            S_SORT_RD:
            begin
                // fetch the value to insert
                crd_en = 1'b1; crd_addr = si_reg[IDX_BITS-1:0];
            end
            S_SORT_LD:
            begin
                crd_en = 1'b1; crd_addr = sp_reg[IDX_BITS-1:0] - 1'b1;
            end
            S_SORT_CMP:
            begin
                // shift up and probe the next lower entry in the same cycle
                if (crd_reg > sv_reg)
                begin
                    cwr_en = 1'b1; cwr_addr = sp_reg[IDX_BITS-1:0]; cwr_data = crd_reg;
                    crd_en = 1'b1; crd_addr = sp_reg[IDX_BITS-1:0] - IDX_BITS'(2);
                end
            end
            S_SORT_PUT:
            begin
                cwr_en = 1'b1; cwr_addr = sp_reg[IDX_BITS-1:0]; cwr_data = sv_reg;
            end
            S_EMIT_RD:
            begin
                crd_en = 1'b1; crd_addr = si_dbl;
            end
            S_EMIT_RD2:
            begin
                crd_en = 1'b1; crd_addr = si_dbl + 1'b1;
            end
            default: ;
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (vwr_en)
            vtx_mem[vwr_addr] <= {in_ch.coord_x, in_ch.coord_y};
        if (vrd_en)
            vrd_reg <= vtx_mem[vrd_addr];
        if (cwr_en)
            crs_mem[cwr_addr] <= cwr_data;
        if (crd_en)
            crd_reg <= crs_mem[crd_addr];
    end

    // sequencer with output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            vcount_reg <= '0;
            ovf_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
            edge_reg   <= '0;
            ccount_reg <= '0;
            si_reg     <= '0;
            sp_reg     <= '0;
            pairs_reg  <= '0;
            k_reg      <= '0;
        end
        else
        begin
            if (out_acc && (state_reg != S_OUT))
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        y_reg <= in_ch.coord_y;
                        unique case (psf_pkg::op_t'(in_ch.operation))
                            psf_pkg::OP_CLEAR:
                            begin
                                vcount_reg <= '0;
                                ovf_reg <= 1'b0;
                            end
                            psf_pkg::OP_ADD:
                            begin
                                if (vcount_reg < CNT_BITS'(MAX_VERTICES))
                                    vcount_reg <= vcount_reg + 1'b1;
                                else
                                    ovf_reg <= 1'b1;
                            end
                            psf_pkg::OP_FILL:
                            begin
                                edge_reg <= '0;
                                ccount_reg <= '0;
                                if (vcount_reg < CNT_BITS'(2))
                                begin
                                    pairs_reg <= '0;
                                    k_reg <= '0;
                                    state_reg <= S_EMIT_RD;
                                end
                                else
                                    state_reg <= S_EDGE_RD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_EDGE_RD:
                begin
                    va_reg <= vrd_reg;
                    state_reg <= S_EDGE_RD2;
                end
                S_EDGE_RD2:
                    state_reg <= S_EDGE_EVAL;
                S_EDGE_EVAL:
                begin
                    xlo_reg <= xlo;
                    neg_reg <= (xhi < xlo);
                    if (hit)
                        state_reg <= S_DIV_WAIT;
                    else if (next_edge == vcount_reg)
                    begin
                        si_reg <= CNT_BITS'(1);
                        state_reg <= S_SORT_RD;
                        sp_reg <= CNT_BITS'(1);
                    end
                    else
                    begin
                        edge_reg <= next_edge;
                        state_reg <= S_EDGE_RD;
                    end
                end
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        ccount_reg <= ccount_reg + 1'b1;
                        if (next_edge == vcount_reg)
                        begin
                            si_reg <= CNT_BITS'(1);
                            sp_reg <= CNT_BITS'(1);
                            state_reg <= S_SORT_RD;
                        end
                        else
                        begin
                            edge_reg <= next_edge;
                            state_reg <= S_EDGE_RD;
                        end
                    end
                end
                S_SORT_RD:
                begin
                    // outer loop check
                    if (si_reg >= ccount_reg)
                    begin
                        k_reg <= '0;
                        if ((ccount_reg >> 1) > CNT_BITS'(psf_pkg::RESULT_LIMIT))
                            pairs_reg <= PAIR_BITS'(psf_pkg::RESULT_LIMIT);
                        else
                            pairs_reg <= PAIR_BITS'(ccount_reg >> 1);
                        state_reg <= S_EMIT_RD;
                    end
                    else
                    begin
                        sp_reg <= si_reg;
                        state_reg <= S_SORT_LD;
                    end
                end
                S_SORT_LD:
                begin
                    sv_reg <= crd_reg;
                    state_reg <= S_SORT_CMP;
                end
                S_SORT_CMP:
                begin
                    // crd_reg holds entry sp-1
                    if (crd_reg > sv_reg)
                    begin
                        sp_reg <= sp_reg - 1'b1;
                        state_reg <= (sp_reg == CNT_BITS'(1)) ? S_SORT_PUT : S_SORT_CMP;
                    end
                    else
                        state_reg <= S_SORT_PUT;
                end
                S_SORT_PUT:
                begin
                    si_reg <= si_reg + 1'b1;
                    state_reg <= S_SORT_RD;
                end
                S_EMIT_RD:
                    state_reg <= (pairs_reg == '0) ? S_OUT : S_EMIT_RD2;
                S_EMIT_RD2:
                begin
                    first_reg <= crd_reg;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!ovalid_reg || out_acc)
                    begin
                        ovalid_reg <= 1'b1;
                        oy_reg   <= y_reg;
                        oovf_reg <= ovf_reg;
                        if (pairs_reg == '0)
                        begin
                            oxf_reg <= '0; oxl_reg <= '0;
                            osv_reg <= 1'b0; olast_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            oxf_reg <= first_reg; oxl_reg <= crd_reg;
                            osv_reg <= 1'b1;
                            olast_reg <= (k_reg + 1'b1 == pairs_reg);
                            k_reg <= k_reg + 1'b1;
                            state_reg <= (k_reg + 1'b1 == pairs_reg) ? S_IDLE : S_EMIT_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid        = ovalid_reg;
    assign out_ch.span_y       = oy_reg;
    assign out_ch.span_x_first = oxf_reg;
    assign out_ch.span_x_last  = oxl_reg;
    assign out_ch.span_valid   = osv_reg;
    assign out_ch.overflow     = oovf_reg;
    assign out_ch.last         = olast_reg;
endmodule

### sim/tb.sv
module tb;
    localparam int NV = 16;
    localparam int CB = 10;

    typedef struct packed {
        logic [CB-1:0] y;
        logic [CB-1:0] xf;
        logic [CB-1:0] xl;
        logic          sv;
        logic          ovf;
        logic          lst;
    } span_t;

    typedef struct {
        psf_pkg::op_t  op;
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        bit            typed;
        span_t         want;
    } row_t;

    logic clk;
    logic rst_n;

    psf_in_if  #(.COORD_BITS(CB)) in_ch ();
    psf_out_if #(.COORD_BITS(CB)) out_ch ();

    polygon_scanline_span_fill_top #(.MAX_VERTICES(NV), .COORD_BITS(CB)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // polygon state kept alongside the block
    logic [CB-1:0] poly_x [NV];
    logic [CB-1:0] poly_y [NV];
    int            poly_n;
    bit            poly_ovf;

    span_t span_queue [$];
    int    mismatches;
    bit    sending_done;

    // update polygon state for one word and queue the spans a fill gives
    task automatic predict_word(input psf_pkg::op_t op, input logic [CB-1:0] x,
                                input logic [CB-1:0] y);
        int     xs [$];
        int     xa, ya, xb, yb, xlo, ylo, xhi, yhi, num, den, q, j, pairs;
        span_t  s;
        case (op)
            psf_pkg::OP_CLEAR:
            begin
                poly_n = 0;
                poly_ovf = 0;
            end
            psf_pkg::OP_ADD:
            begin
                if (poly_n < NV)
                begin
                    poly_x[poly_n] = x;
                    poly_y[poly_n] = y;
                    poly_n++;
                end
                else
                    poly_ovf = 1;
            end
            psf_pkg::OP_FILL:
            begin
                for (int i = 0; i < poly_n; i++)
                begin
                    j = (i + 1 == poly_n) ? 0 : i + 1;
                    xa = poly_x[i]; ya = poly_y[i];
                    xb = poly_x[j]; yb = poly_y[j];
                    if (ya == yb)
                        continue;
                    if (ya < yb)
                    begin
                        xlo = xa; ylo = ya; xhi = xb; yhi = yb;
                    end
                    else
                    begin
                        xlo = xb; ylo = yb; xhi = xa; yhi = ya;
                    end
                    if (y < ylo || y >= yhi)
                        continue;
                    num = (int'(y) - ylo) * (xhi - xlo);
                    den = yhi - ylo;
                    q = num / den;
                    if (num % den != 0 && num < 0)
                        q--;
                    xs = {xs, (xlo + q) & ((1 << CB) - 1)};
                end
                xs.sort();
                pairs = xs.size() / 2;
                if (pairs > psf_pkg::RESULT_LIMIT)
                    pairs = psf_pkg::RESULT_LIMIT;
                if (pairs == 0)
                begin
                    s = '{y, '0, '0, 1'b0, poly_ovf, 1'b1};
                    span_queue = {span_queue, s};
                end
                for (int k = 0; k < pairs; k++)
                begin
                    s.y = y;
                    s.xf = CB'(xs[2*k]);
                    s.xl = CB'(xs[2*k+1]);
                    s.sv = 1;
                    s.ovf = poly_ovf;
                    s.lst = (k + 1 == pairs);
                    span_queue = {span_queue, s};
                end
            end
            default: ;
        endcase
    endtask

    // clock
    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // limit
    initial
    begin
        #30000000;
        $display("RESULT: ERROR");
        $finish;
    end

    row_t rows [$];

    task automatic add_row(input psf_pkg::op_t op, input int x, input int y);
        row_t r;
        r.op = op; r.x = CB'(x); r.y = CB'(y); r.typed = 0; r.want = '0;
        rows = {rows, r};
    endtask

    task automatic add_typed(input psf_pkg::op_t op, input int y, input span_t w);
        row_t r;
        r.op = op; r.x = '0; r.y = CB'(y); r.typed = 1; r.want = w;
        rows = {rows, r};
    endtask

    // send one word, with a random gap ahead of it; valid stays up when there is none
    task automatic send_word(input psf_pkg::op_t op, input logic [CB-1:0] x,
                             input logic [CB-1:0] y);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_ch.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1;
        in_ch.operation <= op;
        in_ch.coord_x   <= x;
        in_ch.coord_y   <= y;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_word(op, x, y);
    endtask

    // random polygon of 3..NV+2 vertices, then several fills and sometimes one random word
    task automatic send_polygon();
        int nv, cx, cy, rr, ymin, ymax;
        nv = $urandom_range(3, NV + 2);
        cx = $urandom_range(0, 1023);
        cy = $urandom_range(0, 1023);
        rr = $urandom_range(4, 400);
        ymin = 1023; ymax = 0;
        send_word(psf_pkg::OP_CLEAR, CB'($urandom), CB'($urandom));
        for (int i = 0; i < nv; i++)
        begin
            int vx, vy;
            if ($urandom_range(0, 5) == 0)
            begin
                vx = $urandom_range(0, 1023);
                vy = $urandom_range(0, 1023);
            end
            else
            begin
                vx = cx + $urandom_range(0, 2 * rr) - rr;
                vy = cy + $urandom_range(0, 2 * rr) - rr;
                vx = vx < 0 ? 0 : (vx > 1023 ? 1023 : vx);
                vy = vy < 0 ? 0 : (vy > 1023 ? 1023 : vy);
            end
            if (vy < ymin) ymin = vy;
            if (vy > ymax) ymax = vy;
            send_word(psf_pkg::OP_ADD, CB'(vx), CB'(vy));
        end
        repeat ($urandom_range(2, 6))
            send_word(psf_pkg::OP_FILL, CB'($urandom), CB'($urandom_range(ymin, ymax)));
        if ($urandom_range(0, 3) == 0)
            send_word(psf_pkg::op_t'($urandom_range(0, 3)), CB'($urandom), CB'($urandom));
    endtask

    // sender
    initial
    begin
        span_t w;
        rst_n = 0;
        in_ch.valid = 0;
        in_ch.operation = psf_pkg::OP_NONE;
        in_ch.coord_x = '0;
        in_ch.coord_y = '0;
        sending_done = 0;
        poly_n = 0;
        poly_ovf = 0;
        mismatches = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed table: extremes, all ops, no-span, overflow, unused code
        add_typed(psf_pkg::OP_FILL, 0, '{10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 1'b1});
        add_row(psf_pkg::OP_ADD, 0, 0);
        add_typed(psf_pkg::OP_FILL, 1023, '{10'd1023, 10'd0, 10'd0, 1'b0, 1'b0, 1'b1});
        add_row(psf_pkg::OP_ADD, 1023, 1023);
        add_row(psf_pkg::OP_ADD, 0, 1023);
        add_row(psf_pkg::OP_FILL, 0, 0);
        add_row(psf_pkg::OP_FILL, 0, 512);
        add_typed(psf_pkg::OP_FILL, 1023, '{10'd1023, 10'd0, 10'd0, 1'b0, 1'b0, 1'b1});
        add_row(psf_pkg::OP_NONE, 1023, 5);
        add_row(psf_pkg::OP_FILL, 0, 1022);
        add_row(psf_pkg::OP_CLEAR, 1023, 1023);
        for (int i = 0; i < 17; i++)
            add_row(psf_pkg::OP_ADD, (i & 1) ? 1023 - i * 20 : i * 20, i * 60);
        add_row(psf_pkg::OP_FILL, 0, 500);
        add_row(psf_pkg::OP_FILL, 1023, 5);

        foreach (rows[i])
        begin
            if (rows[i].typed)
                w = rows[i].want;
            send_word(rows[i].op, rows[i].x, rows[i].y);
            if (rows[i].typed && span_queue.size() > 0 && span_queue[$] !== w)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row %0d: typed %p, computed %p",
                             i, w, span_queue[$]);
            end
        end

        // random part: polygons, then some noise
        for (int p = 0; p < 7; p++)
            send_polygon();
        repeat (20)
            send_word(psf_pkg::op_t'($urandom_range(0, 3)), CB'($urandom), CB'($urandom));
        in_ch.valid <= 0;
        sending_done = 1;
    end

    // receiver
    initial
    begin
        span_t got;
        int    gap;
        out_ch.ready = 0;
        @(posedge rst_n);
        @(posedge clk);
        // long hold-off while the sender keeps going
        repeat (400) @(posedge clk);
        forever
        begin
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            if (gap > 0)
            begin
                out_ch.ready <= 0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
            got = '{out_ch.span_y, out_ch.span_x_first, out_ch.span_x_last,
                    out_ch.span_valid, out_ch.overflow, out_ch.last};
            if (span_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("span with none expected: %p", got);
            end
            else if (got !== span_queue[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("span mismatch: expected %p, actual %p",
                             span_queue[0], got);
                void'(span_queue.pop_front());
            end
            else
                void'(span_queue.pop_front());
        end
    end

    // end of run
    initial
    begin
        int waited;
        waited = 0;
        @(posedge sending_done);
        while (span_queue.size() > 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (2000) @(posedge clk);
        if (mismatches == 0 && span_queue.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
